### hdl/rgbncc_pkg.sv
// Shared types and constants for the RGB nearest-color classifier.
// Item and result structs, controller/datapath command and status groups.
// No dependencies.
`default_nettype none

package rgbncc_pkg;

  localparam int NUM_REF_REGS = 6;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int DIST_W       = 34;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 3'd7;

  localparam logic [2:0] CODE_UNKNOWN = 3'd6;

  localparam logic [DIST_W-1:0] THRESHOLD_RESET    = 34'd85899346;
  localparam logic [7:0]        SAMPLE_COUNT_RESET = 8'd8;

  // channel / step select shared by divider and distance sequence
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_CMP   = 2'd3;

  typedef struct packed {
    logic [15:0] red_count;
    logic [15:0] green_count;
    logic [15:0] blue_count;
    logic [15:0] clear_count;
    logic        burst_start;
  } in_t;

  typedef struct packed {
    logic [2:0]        color_code;
    logic [DIST_W-1:0] best_distance;
    logic              matched;
  } out_t;

  typedef struct packed {
    logic       accept;
    logic       div_load;
    logic       div_step;
    logic       div_last;
    logic       dist_step;
    logic       out_load;
    logic [1:0] ch;
    logic [2:0] ref_idx;
  } cmd_t;

  typedef struct packed {
    logic may_complete;
    logic start_flag;
    logic clear_zero;
  } status_t;

endpackage

`default_nettype wire

### hdl/rgbncc_datapath.sv
// Datapath: burst accumulators, config registers, shared restoring divider,
// squared-distance unit with running minimum, result register.
// Depends on rgbncc_pkg.
`default_nettype none

module rgbncc_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  rgbncc_pkg::in_t                         in_data,
  input  wire                                     cfg_valid,
  input  wire  [rgbncc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [rgbncc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  rgbncc_pkg::cmd_t                        cmd,
  output rgbncc_pkg::status_t                     status,
  output rgbncc_pkg::out_t                        out_data
);

  localparam int F  = FRACTION_BITS;
  localparam int DW = 2 * FRACTION_BITS + 2;

  logic [47:0] ref_color [rgbncc_pkg::NUM_REF_REGS];
  logic [rgbncc_pkg::DIST_W-1:0] threshold;
  logic [7:0] sample_count;

  logic        collecting;
  logic [7:0]  readings_taken;
  logic [23:0] red_sum, green_sum, blue_sum, clear_sum;

  logic [23:0]  rem;
  logic [F-1:0] quo;
  logic         sat;
  logic [F-1:0] rn, gn, bn;

  logic [2*F-1:0] sq;
  logic [DW-1:0]  acc;
  logic [DW-1:0]  best;
  logic [2:0]     best_code;

  logic [7:0]   rd_inc, need;
  logic [23:0]  num;
  logic [24:0]  sh;
  logic         ge;
  logic [F-1:0] quo_next;
  logic [47:0]  ref_word;
  logic [F-1:0] ref_field, norm, diff;
  logic [DW-1:0] total;

  assign rd_inc = readings_taken + 8'd1;
  assign need   = (sample_count == 8'd0) ? 8'd1 : sample_count;

  assign status.may_complete = collecting && (rd_inc >= need);
  assign status.start_flag   = in_data.burst_start;
  assign status.clear_zero   = (clear_sum == 24'd0);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rgbncc_pkg::NUM_REF_REGS; i++) begin
        ref_color[i] <= '0;
      end
      threshold    <= rgbncc_pkg::THRESHOLD_RESET;
      sample_count <= rgbncc_pkg::SAMPLE_COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbncc_pkg::REG_THRESHOLD: begin
          threshold <= cfg_data[rgbncc_pkg::DIST_W-1:0];
        end
        rgbncc_pkg::REG_SAMPLE_COUNT: begin
          sample_count <= cfg_data[7:0];
        end
        default: begin
          ref_color[cfg_index] <= cfg_data;
        end
      endcase
    end
  end

  // burst accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting     <= 1'b0;
      readings_taken <= '0;
      red_sum        <= '0;
      green_sum      <= '0;
      blue_sum       <= '0;
      clear_sum      <= '0;
    end else if (cmd.accept) begin
      if (in_data.burst_start) begin
        collecting     <= 1'b1;
        readings_taken <= '0;
        red_sum        <= '0;
        green_sum      <= '0;
        blue_sum       <= '0;
        clear_sum      <= '0;
      end else if (collecting) begin
        red_sum        <= red_sum + 24'(in_data.red_count);
        green_sum      <= green_sum + 24'(in_data.green_count);
        blue_sum       <= blue_sum + 24'(in_data.blue_count);
        clear_sum      <= clear_sum + 24'(in_data.clear_count);
        readings_taken <= rd_inc;
        if (rd_inc >= need) begin
          collecting <= 1'b0;
        end
      end
    end
  end

  // restoring divider, one quotient bit per step; num >= den saturates
  always_comb begin
    case (cmd.ch)
      rgbncc_pkg::CH_RED:   num = red_sum;
      rgbncc_pkg::CH_GREEN: num = green_sum;
      rgbncc_pkg::CH_BLUE:  num = blue_sum;
      default:              num = '0;
    endcase
    sh       = {rem, 1'b0};
    ge       = (sh >= {1'b0, clear_sum});
    quo_next = {quo[F-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= num;
      sat <= (num >= clear_sum);
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? 24'(sh - {1'b0, clear_sum}) : sh[23:0];
      quo <= quo_next;
      if (cmd.div_last) begin
        case (cmd.ch)
          rgbncc_pkg::CH_RED:   rn <= sat ? '1 : quo_next;
          rgbncc_pkg::CH_GREEN: gn <= sat ? '1 : quo_next;
          rgbncc_pkg::CH_BLUE:  bn <= sat ? '1 : quo_next;
          default: ;
        endcase
      end
    end
  end

  // distance: square one channel per cycle, accumulate, compare on last step
  always_comb begin
    ref_word = (cmd.ref_idx < 3'(rgbncc_pkg::NUM_REF_REGS)) ? ref_color[cmd.ref_idx] : '0;
    case (cmd.ch)
      rgbncc_pkg::CH_RED: begin
        ref_field = ref_word[32 +: F];
        norm      = rn;
      end
      rgbncc_pkg::CH_GREEN: begin
        ref_field = ref_word[16 +: F];
        norm      = gn;
      end
      rgbncc_pkg::CH_BLUE: begin
        ref_field = ref_word[0 +: F];
        norm      = bn;
      end
      default: begin
        ref_field = '0;
        norm      = '0;
      end
    endcase
    diff  = (norm > ref_field) ? norm - ref_field : ref_field - norm;
    total = acc + DW'(sq);
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_step) begin
      sq <= diff * diff;
      case (cmd.ch)
        rgbncc_pkg::CH_GREEN: acc <= DW'(sq);
        rgbncc_pkg::CH_BLUE:  acc <= total;
        rgbncc_pkg::CH_CMP: begin
          if (cmd.ref_idx == 3'd0 || total < best) begin
            best      <= total;
            best_code <= cmd.ref_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (status.clear_zero) begin
        out_data.color_code    <= rgbncc_pkg::CODE_UNKNOWN;
        out_data.best_distance <= '0;
        out_data.matched       <= 1'b0;
      end else if (rgbncc_pkg::DIST_W'(best) <= threshold) begin
        out_data.color_code    <= best_code;
        out_data.best_distance <= rgbncc_pkg::DIST_W'(best);
        out_data.matched       <= 1'b1;
      end else begin
        out_data.color_code    <= rgbncc_pkg::CODE_UNKNOWN;
        out_data.best_distance <= rgbncc_pkg::DIST_W'(best);
        out_data.matched       <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/rgbncc_ctrl.sv
// Controller: input/output handshake, division and distance sequencing.
// Drives the datapath through cmd_t, watches status_t. Depends on rgbncc_pkg.
`default_nettype none

module rgbncc_ctrl #(
  parameter int NUM_REFERENCES = 6,
  parameter int FRACTION_BITS  = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  rgbncc_pkg::status_t status,
  output rgbncc_pkg::cmd_t    cmd
);

  localparam int REFS_USED = (NUM_REFERENCES > rgbncc_pkg::NUM_REF_REGS) ?
                             rgbncc_pkg::NUM_REF_REGS : NUM_REFERENCES;
  localparam int BW = $clog2(FRACTION_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DLOAD = 3'd1;
  localparam logic [2:0] S_DSTEP = 3'd2;
  localparam logic [2:0] S_DIST  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state, state_next;
  logic [1:0]    ch, ch_next;
  logic [BW-1:0] bitcnt, bitcnt_next;
  logic [2:0]    ref_idx, ref_idx_next;
  logic          accept;

  assign in_ready = (state == S_IDLE) && !(out_valid && status.may_complete);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    ch_next      = ch;
    bitcnt_next  = bitcnt;
    ref_idx_next = ref_idx;
    cmd          = '0;
    cmd.accept   = accept;
    cmd.ch       = ch;
    cmd.ref_idx  = ref_idx;
    unique case (state)
      S_IDLE: begin
        if (accept && status.may_complete && !status.start_flag) begin
          state_next = S_DLOAD;
          ch_next    = rgbncc_pkg::CH_RED;
        end
      end
      S_DLOAD: begin
        if (status.clear_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_load = 1'b1;
          bitcnt_next  = '0;
          state_next   = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (bitcnt == BW'(FRACTION_BITS - 1)) begin
          cmd.div_last = 1'b1;
          if (ch == rgbncc_pkg::CH_BLUE) begin
            ch_next      = rgbncc_pkg::CH_RED;
            ref_idx_next = '0;
            state_next   = S_DIST;
          end else begin
            ch_next    = ch + 2'd1;
            state_next = S_DLOAD;
          end
        end else begin
          bitcnt_next = bitcnt + BW'(1);
        end
      end
      S_DIST: begin
        cmd.dist_step = 1'b1;
        if (ch == rgbncc_pkg::CH_CMP) begin
          ch_next = rgbncc_pkg::CH_RED;
          if (ref_idx == 3'(REFS_USED - 1)) begin
            state_next = S_DONE;
          end else begin
            ref_idx_next = ref_idx + 3'd1;
          end
        end else begin
          ch_next = ch + 2'd1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      bitcnt    <= '0;
      ref_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      ch      <= ch_next;
      bitcnt  <= bitcnt_next;
      ref_idx <= ref_idx_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/rgb_nearest_color_classifier_core.sv
// Top level of the RGB nearest-color classifier.
// Instantiates rgbncc_ctrl and rgbncc_datapath; depends on rgbncc_pkg.
//
// Usage:
//   in_*   : one raw sensor reading per transfer. A reading with burst_start
//            clears the sums and is dropped; the next sample_count readings
//            are summed. Readings outside a burst are dropped.
//   out_*  : one classification per completed burst (code, distance, match).
//   cfg_*  : register writes, index 0..7; cfg_ready is always high.
// Throughput: readings that do not end a burst are taken one per cycle. The
//   reading that ends a burst starts a sequence, with in_ready low: red, green
//   and blue are divided by the clear sum in the shared one-bit-per-cycle
//   divider, the squared distance to each of the first min(NUM_REFERENCES,6)
//   references is taken, then the result register is loaded and out_valid
//   rises (a zero clear sum skips straight to the load).
// Stall: the result register holds while out_ready is low; readings keep
//   being taken, except one that would end the next burst, which waits.
// Reset (rst, synchronous): registers to their defaults, no burst open,
//   no result pending.
`default_nettype none

module rgb_nearest_color_classifier_core #(
  parameter int NUM_REFERENCES = 6,
  parameter int FRACTION_BITS  = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  rgbncc_pkg::in_t                    in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output rgbncc_pkg::out_t                   out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [rgbncc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [rgbncc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rgbncc_pkg::cmd_t    cmd;
  rgbncc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  rgbncc_ctrl #(
    .NUM_REFERENCES (NUM_REFERENCES),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rgbncc_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hdl/rgbncc_checker.sv
// Port-level checks for rgb_nearest_color_classifier_core, attached by bind.
// Depends on rgbncc_pkg.
`default_nettype none

module rgbncc_checker (
  input wire              clk,
  input wire              rst,
  input wire              in_valid,
  input wire              in_ready,
  input rgbncc_pkg::in_t  in_data,
  input wire              out_valid,
  input wire              out_ready,
  input rgbncc_pkg::out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // matched flag and code agree
  a_match_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.matched && out_data.color_code < rgbncc_pkg::CODE_UNKNOWN) ||
                  (!out_data.matched && out_data.color_code == rgbncc_pkg::CODE_UNKNOWN))
    else $error("matched flag inconsistent with color code");

  // a reading transfer never produces a result on the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a reading transfer");

  // an unmatched result with zero distance carries the unknown code
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.matched && out_data.best_distance == '0 |->
      out_data.color_code == rgbncc_pkg::CODE_UNKNOWN)
    else $error("unknown result carries bad code");

endmodule

bind rgb_nearest_color_classifier_core rgbncc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### sim/rgbncc_classify_check.sv
// Result checker for the RGB nearest-color classifier: watches the reading, result and
// register-write channels, predicts each classification and compares it with the block.
// Depends on rgbncc_pkg.
`timescale 1ns / 100ps

module rgbncc_classify_check
  import rgbncc_pkg::*;
#(
  parameter int NUM_REFERENCES = 6,
  parameter int FRACTION_BITS  = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  input  wire                    in_ready,
  input  in_t                    in_data,
  input  wire                    out_valid,
  input  wire                    out_ready,
  input  out_t                   out_data,
  input  wire                    cfg_valid,
  input  wire                    cfg_ready,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int REFS_CMP = (NUM_REFERENCES > NUM_REF_REGS) ? NUM_REF_REGS : NUM_REFERENCES;
  localparam logic [63:0] FRAC_MAX = (64'd1 << FRACTION_BITS) - 64'd1;
  localparam logic [63:0] DIST_MASK = (64'd1 << DIST_W) - 64'd1;

  logic [CFG_DATA_W-1:0] ref_color [NUM_REF_REGS];
  logic [DIST_W-1:0]     threshold;
  logic [7:0]            samples;

  logic        burst_open;
  logic [7:0]  taken;
  logic [23:0] red_sum, green_sum, blue_sum, clear_sum;

  out_t expected_colors [$];
  int   reported;

  function automatic logic [63:0] color_ratio(input logic [23:0] num, input logic [23:0] den);
    logic [63:0] q;
    q = ({40'd0, num} << FRACTION_BITS) / {40'd0, den};
    return (q > FRAC_MAX) ? FRAC_MAX : q;
  endfunction

  function automatic logic [63:0] sq_gap(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic out_t predict_color();
    out_t        res;
    logic [63:0] rn, gn, bn, d, best;
    logic [2:0]  code;
    res = '0;
    best = '0;
    code = '0;
    if (clear_sum == 24'd0) begin
      res.color_code = CODE_UNKNOWN;
      return res;
    end
    rn = color_ratio(red_sum, clear_sum);
    gn = color_ratio(green_sum, clear_sum);
    bn = color_ratio(blue_sum, clear_sum);
    for (int i = 0; i < REFS_CMP; i++) begin
      d = sq_gap(rn, {16'd0, ref_color[i]} >> 32 & FRAC_MAX)
        + sq_gap(gn, {16'd0, ref_color[i]} >> 16 & FRAC_MAX)
        + sq_gap(bn, {16'd0, ref_color[i]} & FRAC_MAX);
      // lowest index wins a tie
      if (i == 0 || d < best) begin
        best = d;
        code = i[2:0];
      end
    end
    best = best & DIST_MASK;
    res.best_distance = best[DIST_W-1:0];
    if (best <= {30'd0, threshold}) begin
      res.color_code = code;
      res.matched    = 1'b1;
    end else begin
      res.color_code = CODE_UNKNOWN;
      res.matched    = 1'b0;
    end
    return res;
  endfunction

  task automatic take_reading(input in_t item);
    logic [7:0] need;
    if (item.burst_start) begin
      burst_open = 1'b1;
      taken      = '0;
      red_sum    = '0;
      green_sum  = '0;
      blue_sum   = '0;
      clear_sum  = '0;
    end else if (burst_open) begin
      red_sum   = red_sum + item.red_count;
      green_sum = green_sum + item.green_count;
      blue_sum  = blue_sum + item.blue_count;
      clear_sum = clear_sum + item.clear_count;
      taken     = taken + 8'd1;
      need      = (samples == 8'd0) ? 8'd1 : samples;
      if (taken >= need) begin
        burst_open = 1'b0;
        expected_colors.push_back(predict_color());
      end
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_colors.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("unexpected result: code %0d distance %0d matched %0b",
                 got.color_code, got.best_distance, got.matched);
      end
    end else begin
      want = expected_colors.pop_front();
      if (got.color_code !== want.color_code || got.best_distance !== want.best_distance ||
          got.matched !== want.matched) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("result mismatch: expected code %0d distance %0d matched %0b, got code %0d distance %0d matched %0b",
                   want.color_code, want.best_distance, want.matched,
                   got.color_code, got.best_distance, got.matched);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REF_REGS; i++) begin
        ref_color[i] = '0;
      end
      threshold  = THRESHOLD_RESET;
      samples    = SAMPLE_COUNT_RESET;
      burst_open = 1'b0;
      taken      = '0;
      red_sum    = '0;
      green_sum  = '0;
      blue_sum   = '0;
      clear_sum  = '0;
      expected_colors.delete();
      fail_count = 0;
      reported   = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < NUM_REF_REGS) begin
          ref_color[cfg_index] = cfg_data;
        end else if (cfg_index == REG_THRESHOLD) begin
          threshold = cfg_data[DIST_W-1:0];
        end else if (cfg_index == REG_SAMPLE_COUNT) begin
          samples = cfg_data[7:0];
        end
      end
      if (in_valid && in_ready) begin
        take_reading(in_data);
      end
    end
    pending = expected_colors.size();
  end

endmodule

### sim/testbench.sv
// Top of the classifier testbench: clock, reset, reading and register-write stimulus,
// random back-pressure, and the verdict. Depends on rgbncc_pkg,
// rgb_nearest_color_classifier_core and rgbncc_classify_check.
`timescale 1ns / 100ps

module testbench;
  import rgbncc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_REF_RED   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REF_WHITE = 3'd5;
  localparam logic [DIST_W-1:0] THRESHOLD_MAX = 34'd12884508675;
  localparam int PHASE_ITEMS = 70;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  in_t                    in_data = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  wire                    in_ready;
  wire                    out_valid;
  wire                    cfg_ready;
  out_t                   out_data;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  logic [CFG_DATA_W-1:0] ref_table [NUM_REF_REGS];
  logic [7:0]            cur_samples = SAMPLE_COUNT_RESET;
  logic                  burst_left_open = 1'b0;

  logic [CFG_DATA_W-1:0] palette [NUM_REF_REGS] = '{
    {16'd31523, 16'd15729, 16'd18022},
    {16'd32244, 16'd16646, 16'd13894},
    {16'd25363, 16'd24052, 16'd13500},
    {16'd16384, 16'd27001, 16'd19661},
    {16'd13107, 16'd19661, 16'd31457},
    {16'd21627, 16'd21627, 16'd21627}
  };

  rgb_nearest_color_classifier_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  rgbncc_classify_check classify_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx < NUM_REF_REGS) begin
      ref_table[idx] = value;
    end else if (idx == REG_SAMPLE_COUNT) begin
      cur_samples = value[7:0];
    end
  endtask

  // hold off until every classification is out and the divider has gone quiet
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic in_t reading(input logic [15:0] r, input logic [15:0] g,
                                  input logic [15:0] b, input logic [15:0] c);
    in_t item;
    item.red_count   = r;
    item.green_count = g;
    item.blue_count  = b;
    item.clear_count = c;
    item.burst_start = 1'b0;
    return item;
  endfunction

  function automatic in_t any_reading();
    return reading($urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic in_t burst_marker();
    in_t item;
    item = any_reading();
    item.burst_start = 1'b1;
    return item;
  endfunction

  // reading whose color/clear ratios sit near a reference, spread in per-mille of clear
  function automatic in_t near(input logic [CFG_DATA_W-1:0] color, input int spread);
    longint      clear, v;
    logic [15:0] comp [3];
    clear = $urandom_range(65535, 256);
    for (int k = 0; k < 3; k++) begin
      v = (longint'(color[47 - 16 * k -: 16]) * clear) >>> 16;
      if (spread > 0) begin
        v = v + (longint'($urandom_range(2 * spread)) - spread) * clear / 1000;
      end
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      comp[k] = v[15:0];
    end
    return reading(comp[0], comp[1], comp[2], clear[15:0]);
  endfunction

  function automatic in_t pick_reading(input int target);
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return near(ref_table[target], $urandom_range(20));
    if (pick == 7) return near(ref_table[target], 300);
    return any_reading();
  endfunction

  task automatic configure_random();
    int          pick;
    logic [63:0] wide;
    for (int i = 0; i < NUM_REF_REGS; i++) begin
      pick = $urandom_range(9);
      wide = {$urandom, $urandom};
      if (pick < 6) begin
        write_reg(i[2:0], palette[$urandom_range(NUM_REF_REGS - 1)] ^ {3{5'd0, wide[10:0]}});
      end else if (pick < 8) begin
        write_reg(i[2:0], wide[47:0]);
      end else if (pick == 8 && i > 0) begin
        write_reg(i[2:0], ref_table[i - 1]);
      end else begin
        write_reg(i[2:0], wide[0] ? '1 : '0);
      end
    end
    pick = $urandom_range(9);
    wide = {$urandom, $urandom};
    case (pick)
      0:       write_reg(REG_THRESHOLD, '0);
      1:       write_reg(REG_THRESHOLD, THRESHOLD_MAX);
      2, 3:    write_reg(REG_THRESHOLD, THRESHOLD_RESET);
      4, 5:    write_reg(REG_THRESHOLD, wide % (64'(THRESHOLD_MAX) + 1));
      default: write_reg(REG_THRESHOLD, wide[27:0]);
    endcase
    pick = $urandom_range(9);
    if (pick == 0) begin
      write_reg(REG_SAMPLE_COUNT, '0);
    end else if (pick == 1) begin
      write_reg(REG_SAMPLE_COUNT, $urandom_range(12, 5));
    end else begin
      write_reg(REG_SAMPLE_COUNT, $urandom_range(4, 1));
    end
  endtask

  task automatic run_phase(input int budget);
    int done, action, need, target, partial;
    done = 0;
    while (done < budget) begin
      need   = (cur_samples == 8'd0) ? 1 : cur_samples;
      action = $urandom_range(99);
      target = $urandom_range(NUM_REF_REGS - 1);
      if (action < 80) begin
        send(burst_marker());
        for (int k = 0; k < need; k++) send(pick_reading(target));
        done = done + need + 1;
        burst_left_open = 1'b0;
      end else if (action < 88) begin
        // cut-short burst, restarted later by the next marker
        partial = $urandom_range(need - 1);
        send(burst_marker());
        for (int k = 0; k < partial; k++) send(pick_reading(target));
        done = done + partial + 1;
        burst_left_open = 1'b1;
      end else if (action < 94 && !burst_left_open) begin
        send(any_reading());
      end else begin
        send(burst_marker());
        for (int k = 0; k < need; k++) send(reading($urandom, $urandom, $urandom, 16'd0));
        done = done + need + 1;
        burst_left_open = 1'b0;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REF_REGS; i++) begin
      ref_table[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 67;

    // readings outside a burst are dropped
    send(any_reading());
    send(reading('1, '1, '1, '1));
    // reset settings: eight readings, four full-scale and four empty, ratio saturates, all refs tie
    send(burst_marker());
    for (int k = 0; k < 4; k++) send(reading('1, '1, '1, '1));
    for (int k = 0; k < 4; k++) send(reading('0, '0, '0, '0));
    send(any_reading());

    settle();
    for (int i = 0; i < NUM_REF_REGS; i++) write_reg(i[2:0], palette[i]);
    write_reg(REG_THRESHOLD, THRESHOLD_RESET);
    write_reg(REG_SAMPLE_COUNT, 8'd1);
    send(burst_marker());
    send(near(palette[0], 0));
    send(burst_marker());
    send(reading('1, '1, '1, '0));

    settle();
    write_reg(REG_REF_RED + 3'd1, palette[0]);
    send(burst_marker());
    send(near(palette[0], 0));

    settle();
    write_reg(REG_SAMPLE_COUNT, 8'd0);
    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_REF_WHITE, {3{16'd32768}});
    send(burst_marker());
    send(reading(16'd16384, 16'd16384, 16'd16384, 16'd32768));

    settle();
    write_reg(REG_SAMPLE_COUNT, 8'd2);
    write_reg(REG_THRESHOLD, THRESHOLD_MAX);
    send(burst_marker());
    send(near(palette[4], 5));
    send(burst_marker());
    send(near(palette[2], 5));
    send(near(palette[2], 5));

    // sample count lowered while a burst is open
    settle();
    write_reg(REG_SAMPLE_COUNT, 8'd3);
    send(burst_marker());
    send(near(palette[3], 5));
    send(near(palette[3], 5));
    settle();
    write_reg(REG_SAMPLE_COUNT, 8'd1);
    send(near(palette[3], 5));

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 67 : 0;
      recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 16 : 0;
      for (int p = 0; p < 4; p++) begin
        settle();
        configure_random();
        run_phase(PHASE_ITEMS);
      end
    end

    // longest burst
    settle();
    write_reg(REG_SAMPLE_COUNT, 8'd255);
    write_reg(REG_THRESHOLD, THRESHOLD_RESET);
    send(burst_marker());
    for (int k = 0; k < 255; k++) send(near(ref_table[1], 10));

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### rgb_nearest_color_classifier_core.f
hdl/rgbncc_pkg.sv
hdl/rgbncc_datapath.sv
hdl/rgbncc_ctrl.sv
hdl/rgb_nearest_color_classifier_core.sv
hdl/rgbncc_checker.sv
sim/rgbncc_classify_check.sv
sim/testbench.sv
